[hw/rtl/bbcd_pkg.sv]
// Shared types and constants for the blob bounding box center and depth block.
// Used by the front tracker, the box queue, the back calculator and the top level.
package bbcd_pkg;

	localparam int MAX_DIM_DEF  = 1024;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] DIST_RESET = 16'd2048;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 80;

	// root and quotient step counts
	localparam int ROOT_STEPS = 19;
	localparam int DIV_STEPS  = 35;

	// closed bounding box of one blob
	typedef struct packed {
		logic [9:0]  max_col;
		logic [9:0]  max_row;
		logic [10:0] min_col;
		logic [10:0] min_row;
	} box_t;

	// queue handshake between the queue and the back calculator
	typedef struct packed {
		logic valid;
		box_t box;
	} box_stream_t;

endpackage

[hw/rtl/bbcd_front.sv]
// Front tracker: accepts pixel items and keeps the running bounding box.
// Depends on bbcd_pkg; pushes each closed box into bbcd_queue.
module bbcd_front import bbcd_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [15:0] pixel_value,
	input  logic [9:0]  col,
	input  logic [9:0]  row,
	input  logic [10:0] blob_cols,
	input  logic [10:0] blob_rows,
	input  logic        last_pixel,
	output logic        push,
	output box_t        push_box
);

	logic [9:0]  max_col_q, max_row_q;
	logic [10:0] min_col_q, min_row_q;
	logic        open_q;

	logic [9:0]  base_max_col, base_max_row;
	logic [10:0] base_min_col, base_min_row;
	box_t        next_box;

	function automatic logic [10:0] clamp_dim(input logic [10:0] v);
		if (32'(v) > 32'(MAX_DIM))
			return 11'(MAX_DIM);
		return v;
	endfunction

	always_comb begin
		// start a fresh box on the first item of a blob
		if (open_q) begin
			base_max_col = max_col_q;
			base_max_row = max_row_q;
			base_min_col = min_col_q;
			base_min_row = min_row_q;
		end else begin
			base_max_col = '0;
			base_max_row = '0;
			base_min_col = clamp_dim(blob_cols);
			base_min_row = clamp_dim(blob_rows);
		end
		next_box.max_col = base_max_col;
		next_box.max_row = base_max_row;
		next_box.min_col = base_min_col;
		next_box.min_row = base_min_row;
		if (pixel_value != 16'd0) begin
			if (col > base_max_col)
				next_box.max_col = col;
			if (row > base_max_row)
				next_box.max_row = row;
			if ({1'b0, col} < base_min_col)
				next_box.min_col = {1'b0, col};
			if ({1'b0, row} < base_min_row)
				next_box.min_row = {1'b0, row};
		end
	end

	assign push     = accept && last_pixel;
	assign push_box = next_box;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			max_col_q <= '0;
			max_row_q <= '0;
			min_col_q <= '0;
			min_row_q <= '0;
		end else if (accept) begin
			open_q    <= !last_pixel;
			max_col_q <= next_box.max_col;
			max_row_q <= next_box.max_row;
			min_col_q <= next_box.min_col;
			min_row_q <= next_box.min_row;
		end
	end

endmodule

[hw/rtl/bbcd_queue.sv]
// Short queue of closed boxes between the front tracker and the back calculator.
// Depends on bbcd_pkg for box_t and the queue depth.
module bbcd_queue import bbcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  box_t        push_box,
	output logic        full,
	input  logic        pop,
	output box_stream_t head
);

	box_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.box   = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (32'(p) == QUEUE_DEPTH - 1)
			return '0;
		return p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_box;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

[hw/rtl/bbcd_back.sv]
// Back calculator: center sums, radius by bit-serial square root and depth by
// restoring division, one box at a time. Depends on bbcd_pkg.
module bbcd_back import bbcd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  box_stream_t            head,
	output logic                   pop,
	input  logic [15:0]            distance_q8,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQR  = 5'b00010,
		ST_ROOT = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t      state_q;
	logic [5:0]  cnt_q;
	logic [11:0] cx_q, cy_q;
	logic [10:0] adx_q, ady_q;
	logic [37:0] rad_q;
	logic [20:0] srem_q;
	logic [18:0] root_q;
	logic [34:0] quo_q;
	logic [15:0] drem_q;
	logic        out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic signed [11:0] dx, dy;
	logic [22:0] sum_sq;
	logic [22:0] s_shift, s_trial;
	logic [20:0] srem_next;
	logic [18:0] root_next;
	logic [16:0] d_shift;
	logic [15:0] div_d;
	logic [15:0] drem_next;
	logic        qbit;
	logic [17:0] radius_out;
	logic [31:0] depth_out;
	logic        out_free;

	assign dx = signed'({2'b00, head.box.max_col}) - signed'({1'b0, head.box.min_col});
	assign dy = signed'({2'b00, head.box.max_row}) - signed'({1'b0, head.box.min_row});
	assign sum_sq = 23'(adx_q * adx_q) + 23'(ady_q * ady_q);

	// one root digit per cycle
	always_comb begin
		s_shift = {srem_q, rad_q[37:36]};
		s_trial = {2'b00, root_q, 2'b01};
		if (s_shift >= s_trial) begin
			srem_next = 21'(s_shift - s_trial);
			root_next = {root_q[17:0], 1'b1};
		end else begin
			srem_next = s_shift[20:0];
			root_next = {root_q[17:0], 1'b0};
		end
	end

	// one quotient bit per cycle; a zero distance divides as one
	assign div_d   = (distance_q8 == 16'd0) ? 16'd1 : distance_q8;
	assign d_shift = {drem_q, quo_q[34]};
	assign qbit    = (d_shift >= {1'b0, div_d});
	assign drem_next = qbit ? 16'(d_shift - {1'b0, div_d}) : d_shift[15:0];

	assign radius_out = (root_q[18]) ? 18'h3FFFF : root_q[17:0];
	assign depth_out  = (quo_q > 35'h0_8001_0000) ? 32'h8000_0000
	                                               : 32'(35'd65536 - quo_q);
	assign out_free   = !out_valid_q || m_tready;
	assign pop        = (state_q == ST_IDLE) && head.valid;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cx_q  <= {2'b00, head.box.max_col} + {1'b0, head.box.min_col};
				cy_q  <= {2'b00, head.box.max_row} + {1'b0, head.box.min_row};
				adx_q <= dx[11] ? 11'(-dx) : dx[10:0];
				ady_q <= dy[11] ? 11'(-dy) : dy[10:0];
			end
			ST_SQR: begin
				rad_q  <= {1'b0, sum_sq, 14'd0};
				srem_q <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				rad_q  <= {rad_q[35:0], 2'b00};
				srem_q <= srem_next;
				root_q <= root_next;
				// load the dividend with the final root
				quo_q  <= {root_next, 16'd0};
				drem_q <= '0;
			end
			ST_DIV: begin
				quo_q  <= {quo_q[33:0], qbit};
				drem_q <= drem_next;
			end
			ST_DONE: begin
				if (out_free)
					out_data_q <= {6'd0, depth_out, radius_out, cy_q, cx_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid)
						state_q <= ST_SQR;
				end
				ST_SQR: begin
					cnt_q   <= 6'(ROOT_STEPS - 1);
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (cnt_q == '0) begin
						cnt_q   <= 6'(DIV_STEPS - 1);
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q - 6'd1;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[hw/rtl/blob_bbox_center_depth.sv]
// Top level of the blob bounding box center and depth block.
// Depends on bbcd_pkg, bbcd_front, bbcd_queue and bbcd_back.
//
//   channel | direction | fields
//   s_*     | in        | tdata: pixel_value, col, row, blob_cols, blob_rows; tlast: last_pixel
//   m_*     | out       | tdata: center_x2, center_y2, radius_q8, depth_q16
//   cfg_*   | in        | distance_q8, written when cfg_we is high
//
// Pixel items are taken one per cycle while the box queue has room.
// In the back calculator each blob then passes through the setup states ST_IDLE
// and ST_SQR, 19 root steps, 35 quotient steps and the output state ST_DONE.
// The queue holds two closed boxes; s_tready drops while it is full.
// Reset clears the box tracker, queue and output valid; distance_q8 resets to 8.0.
module blob_bbox_center_depth import bbcd_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// pixel_value[15:0], col[25:16], row[35:26], blob_cols[46:36], blob_rows[57:47]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// center_x2[11:0], center_y2[23:12], radius_q8[41:24], depth_q16[73:42]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata
);

	logic [15:0] distance_q;
	logic        accept;
	logic        push;
	logic        full;
	logic        pop;
	box_t        push_box;
	box_stream_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			distance_q <= DIST_RESET;
		else if (cfg_we)
			distance_q <= cfg_wdata;
	end

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	bbcd_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.pixel_value(s_tdata[15:0]),
		.col        (s_tdata[25:16]),
		.row        (s_tdata[35:26]),
		.blob_cols  (s_tdata[46:36]),
		.blob_rows  (s_tdata[57:47]),
		.last_pixel (s_tlast),
		.push       (push),
		.push_box   (push_box)
	);

	bbcd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_box(push_box),
		.full    (full),
		.pop     (pop),
		.head    (head)
	);

	bbcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.distance_q8(distance_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
